>>> rtl/core/block_stream_field_parser_core_assert.svh
// Assertion macros used by the block stream field parser step logic.
`ifndef BLOCK_STREAM_FIELD_PARSER_CORE_ASSERT_SVH
`define BLOCK_STREAM_FIELD_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Immediate-implication check, disabled while reset is asserted.
`define BSFP_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bsfp assertion failed");
// Next-cycle implication check, disabled while reset is asserted.
`define BSFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bsfp assertion failed");
`else
`define BSFP_ASSERT(lbl, clk, rstn, ante, cons)
`define BSFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/bsfp_pkg.sv
// Types, constants and decode functions of the block stream field parser.
`timescale 1ns / 1ps
package bsfp_pkg;

    localparam int PHASE_W = 22;

    typedef enum logic [PHASE_W-1:0] {
        PH_MAGIC        = 22'h000001,
        PH_SIZE         = 22'h000002,
        PH_VERSION      = 22'h000004,
        PH_PREVHASH     = 22'h000008,
        PH_MERKLE       = 22'h000010,
        PH_TIME         = 22'h000020,
        PH_TARGET       = 22'h000040,
        PH_NONCE        = 22'h000080,
        PH_TXCOUNT      = 22'h000100,
        PH_TXVER        = 22'h000200,
        PH_INCOUNT      = 22'h000400,
        PH_INHASH       = 22'h000800,
        PH_ININDEX      = 22'h001000,
        PH_INSCRIPTLEN  = 22'h002000,
        PH_INSCRIPT     = 22'h004000,
        PH_INSEQ        = 22'h008000,
        PH_OUTCOUNT     = 22'h010000,
        PH_OUTVALUE     = 22'h020000,
        PH_OUTSCRIPTLEN = 22'h040000,
        PH_OUTSCRIPT    = 22'h080000,
        PH_LOCKTIME     = 22'h100000,
        PH_ERROR        = 22'h200000
    } t_phase;

    localparam logic [4:0] K_MAGIC        = 5'd0;
    localparam logic [4:0] K_SIZE         = 5'd1;
    localparam logic [4:0] K_VERSION      = 5'd2;
    localparam logic [4:0] K_PREVHASH     = 5'd3;
    localparam logic [4:0] K_MERKLE       = 5'd4;
    localparam logic [4:0] K_TIME         = 5'd5;
    localparam logic [4:0] K_TARGET       = 5'd6;
    localparam logic [4:0] K_NONCE        = 5'd7;
    localparam logic [4:0] K_TXCOUNT      = 5'd8;
    localparam logic [4:0] K_TXVER        = 5'd9;
    localparam logic [4:0] K_INCOUNT      = 5'd10;
    localparam logic [4:0] K_INHASH       = 5'd11;
    localparam logic [4:0] K_ININDEX      = 5'd12;
    localparam logic [4:0] K_INSCRIPTLEN  = 5'd13;
    localparam logic [4:0] K_INSCRIPT     = 5'd14;
    localparam logic [4:0] K_INSEQ        = 5'd15;
    localparam logic [4:0] K_OUTCOUNT     = 5'd16;
    localparam logic [4:0] K_OUTVALUE     = 5'd17;
    localparam logic [4:0] K_OUTSCRIPTLEN = 5'd18;
    localparam logic [4:0] K_OUTSCRIPT    = 5'd19;
    localparam logic [4:0] K_LOCKTIME     = 5'd20;
    localparam logic [4:0] K_ERROR        = 5'd21;

    // Variable-length integer prefixes and the byte counts they announce.
    localparam logic [7:0] VI_PFX_2 = 8'hfd;
    localparam logic [7:0] VI_PFX_4 = 8'hfe;
    localparam logic [3:0] VI_LEN_2 = 4'd2;
    localparam logic [3:0] VI_LEN_4 = 4'd4;
    localparam logic [3:0] VI_LEN_8 = 4'd8;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [4:0]  field_kind;
        logic [4:0]  byte_offset;
        logic        field_last;
        logic        value_valid;
        logic [63:0] varint_value;
        logic [31:0] tx_number;
        logic [31:0] item_number;
        logic        block_last;
    } t_result;

    function automatic logic [4:0] phase_kind(input t_phase ph);
        logic [4:0] k;
        unique case (ph)
            PH_MAGIC:        k = K_MAGIC;
            PH_SIZE:         k = K_SIZE;
            PH_VERSION:      k = K_VERSION;
            PH_PREVHASH:     k = K_PREVHASH;
            PH_MERKLE:       k = K_MERKLE;
            PH_TIME:         k = K_TIME;
            PH_TARGET:       k = K_TARGET;
            PH_NONCE:        k = K_NONCE;
            PH_TXCOUNT:      k = K_TXCOUNT;
            PH_TXVER:        k = K_TXVER;
            PH_INCOUNT:      k = K_INCOUNT;
            PH_INHASH:       k = K_INHASH;
            PH_ININDEX:      k = K_ININDEX;
            PH_INSCRIPTLEN:  k = K_INSCRIPTLEN;
            PH_INSCRIPT:     k = K_INSCRIPT;
            PH_INSEQ:        k = K_INSEQ;
            PH_OUTCOUNT:     k = K_OUTCOUNT;
            PH_OUTVALUE:     k = K_OUTVALUE;
            PH_OUTSCRIPTLEN: k = K_OUTSCRIPTLEN;
            PH_OUTSCRIPT:    k = K_OUTSCRIPT;
            PH_LOCKTIME:     k = K_LOCKTIME;
            default:         k = K_ERROR;
        endcase
        return k;
    endfunction

    // Byte length of the fixed-size fields; other phases never consult it.
    function automatic logic [5:0] fixed_len(input t_phase ph);
        logic [5:0] n;
        unique case (ph) inside
            PH_PREVHASH, PH_MERKLE, PH_INHASH: n = 6'd32;
            PH_OUTVALUE:                       n = 6'd8;
            default:                           n = 6'd4;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/bsfp_step.sv
// Parser state registers and the per-byte field tagging logic.
`timescale 1ns / 1ps
`include "block_stream_field_parser_core_assert.svh"
module bsfp_step
    import bsfp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    output t_result    o_res
);

    localparam int CW    = COUNT_WIDTH;
    localparam int NUM_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

    t_phase          r_phase, n_phase;
    logic [5:0]      r_cnt, n_cnt;
    logic [3:0]      r_vlen, n_vlen;
    logic [63:0]     r_acc, n_acc;
    logic [CW-1:0]   r_tx_left, n_tx_left;
    logic [CW-1:0]   r_tx_idx, n_tx_idx;
    logic [CW-1:0]   r_in_left, n_in_left;
    logic [CW-1:0]   r_out_left, n_out_left;
    logic [CW-1:0]   r_entry, n_entry;
    logic [CW-1:0]   r_script_left, n_script_left;

    logic [CW-1:0]   tx_dec, in_dec, out_dec, script_dec, entry_inc;
    logic [5:0]      cnt_inc;
    logic [2:0]      sel;
    logic [63:0]     acc_sum, v;
    logic [CW-1:0]   vc;
    logic            done, over, do_enter;
    t_phase          enter_ph;
    t_result         res;

    assign tx_dec     = r_tx_left - 1'b1;
    assign in_dec     = r_in_left - 1'b1;
    assign out_dec    = r_out_left - 1'b1;
    assign script_dec = r_script_left - 1'b1;
    assign entry_inc  = r_entry + 1'b1;
    assign cnt_inc    = r_cnt + 6'd1;
    // Varint data bytes are numbered from one; byte k lands at bit 8*(k-1).
    assign sel        = r_cnt[2:0] - 3'd1;

    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_vlen        = r_vlen;
        n_acc         = r_acc;
        n_tx_left     = r_tx_left;
        n_tx_idx      = r_tx_idx;
        n_in_left     = r_in_left;
        n_out_left    = r_out_left;
        n_entry       = r_entry;
        n_script_left = r_script_left;
        do_enter      = 1'b0;
        enter_ph      = r_phase;
        done          = 1'b0;
        v             = '0;
        acc_sum       = r_acc;
        acc_sum[{sel, 3'b000} +: 8] = i_data_byte;
        res              = '0;
        res.byte_out     = i_data_byte;
        res.field_kind   = phase_kind(r_phase);
        res.byte_offset  = r_cnt[4:0];

        if (r_phase != PH_ERROR && r_phase != PH_MAGIC && r_phase != PH_SIZE &&
            r_phase != PH_VERSION && r_phase != PH_PREVHASH && r_phase != PH_MERKLE &&
            r_phase != PH_TIME && r_phase != PH_TARGET && r_phase != PH_NONCE &&
            r_phase != PH_TXCOUNT) begin
            res.tx_number = 32'(r_tx_idx[NUM_W-1:0]);
        end
        if (r_phase == PH_INHASH || r_phase == PH_ININDEX || r_phase == PH_INSCRIPTLEN ||
            r_phase == PH_INSCRIPT || r_phase == PH_INSEQ || r_phase == PH_OUTVALUE ||
            r_phase == PH_OUTSCRIPTLEN || r_phase == PH_OUTSCRIPT) begin
            res.item_number = 32'(r_entry[NUM_W-1:0]);
        end

        unique case (r_phase) inside
            PH_TXCOUNT, PH_INCOUNT, PH_INSCRIPTLEN, PH_OUTCOUNT, PH_OUTSCRIPTLEN: begin
                if (r_cnt == 6'd0) begin
                    if (i_data_byte < VI_PFX_2) begin
                        v    = {56'd0, i_data_byte};
                        done = 1'b1;
                    end else begin
                        n_vlen = (i_data_byte == VI_PFX_2) ? VI_LEN_2 :
                                 (i_data_byte == VI_PFX_4) ? VI_LEN_4 : VI_LEN_8;
                        n_acc  = '0;
                        n_cnt  = 6'd1;
                    end
                end else begin
                    n_acc = acc_sum;
                    if (r_cnt >= {2'b00, r_vlen}) begin
                        v    = acc_sum;
                        done = 1'b1;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            PH_INSCRIPT, PH_OUTSCRIPT: begin
                n_cnt         = cnt_inc;
                n_script_left = script_dec;
                if (script_dec == '0) begin
                    res.field_last = 1'b1;
                    do_enter       = 1'b1;
                    if (r_phase == PH_INSCRIPT) begin
                        enter_ph = PH_INSEQ;
                    end else begin
                        n_out_left = out_dec;
                        n_entry    = entry_inc;
                        enter_ph   = (out_dec == '0) ? PH_LOCKTIME : PH_OUTVALUE;
                    end
                end
            end
            PH_MAGIC, PH_SIZE, PH_VERSION, PH_PREVHASH, PH_MERKLE, PH_TIME, PH_TARGET,
            PH_NONCE, PH_TXVER, PH_INHASH, PH_ININDEX, PH_INSEQ, PH_OUTVALUE,
            PH_LOCKTIME: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= fixed_len(r_phase)) begin
                    res.field_last = 1'b1;
                    do_enter       = 1'b1;
                    if (r_phase == PH_INSEQ) begin
                        n_in_left = in_dec;
                        n_entry   = entry_inc;
                        enter_ph  = (in_dec == '0) ? PH_OUTCOUNT : PH_INHASH;
                    end else if (r_phase == PH_LOCKTIME) begin
                        n_tx_left = tx_dec;
                        n_tx_idx  = r_tx_idx + 1'b1;
                        if (tx_dec == '0) begin
                            enter_ph       = PH_MAGIC;
                            res.block_last = 1'b1;
                        end else begin
                            enter_ph = PH_TXVER;
                        end
                    end else begin
                        // The remaining fixed fields advance to the next code in order.
                        enter_ph = t_phase'(r_phase << 1);
                    end
                end
            end
            default: begin
                n_phase         = PH_ERROR;
                res             = '0;
                res.byte_out    = i_data_byte;
                res.field_kind  = K_ERROR;
            end
        endcase

        // A count too wide for the counters is still reported, then latches the error phase.
        over = (v >> COUNT_WIDTH) != 64'd0;
        vc   = v[CW-1:0];
        if (done) begin
            res.field_last   = 1'b1;
            res.value_valid  = 1'b1;
            res.varint_value = v;
            do_enter         = 1'b1;
            if (over) begin
                enter_ph = PH_ERROR;
            end else if (r_phase == PH_TXCOUNT) begin
                n_tx_left = vc;
                n_tx_idx  = '0;
                if (vc == '0) begin
                    enter_ph       = PH_MAGIC;
                    res.block_last = 1'b1;
                end else begin
                    enter_ph = PH_TXVER;
                end
            end else if (r_phase == PH_INCOUNT) begin
                n_in_left = vc;
                n_entry   = '0;
                enter_ph  = (vc == '0) ? PH_OUTCOUNT : PH_INHASH;
            end else if (r_phase == PH_OUTCOUNT) begin
                n_out_left = vc;
                n_entry    = '0;
                enter_ph   = (vc == '0) ? PH_LOCKTIME : PH_OUTVALUE;
            end else if (r_phase == PH_INSCRIPTLEN) begin
                n_script_left = vc;
                enter_ph      = (vc == '0) ? PH_INSEQ : PH_INSCRIPT;
            end else begin
                n_script_left = vc;
                if (vc == '0) begin
                    n_out_left = out_dec;
                    n_entry    = entry_inc;
                    enter_ph   = (out_dec == '0) ? PH_LOCKTIME : PH_OUTVALUE;
                end else begin
                    enter_ph = PH_OUTSCRIPT;
                end
            end
        end

        if (do_enter) begin
            n_phase = enter_ph;
            n_cnt   = 6'd0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MAGIC;
            r_cnt         <= 6'd0;
            r_tx_left     <= '0;
            r_tx_idx      <= '0;
            r_in_left     <= '0;
            r_out_left    <= '0;
            r_entry       <= '0;
            r_script_left <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_tx_left     <= n_tx_left;
            r_tx_idx      <= n_tx_idx;
            r_in_left     <= n_in_left;
            r_out_left    <= n_out_left;
            r_entry       <= n_entry;
            r_script_left <= n_script_left;
        end
    end

    // The varint length and partial value are only meaningful inside a varint field.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_vlen <= n_vlen;
            r_acc  <= n_acc;
        end
    end

    `BSFP_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, r_phase == PH_ERROR, r_phase == PH_ERROR)
    `BSFP_ASSERT(a_value_ends_field, i_clk, i_rst_n, res.value_valid, res.field_last)
    `BSFP_ASSERT(a_block_end_place, i_clk, i_rst_n, res.block_last, res.field_last && (r_phase == PH_TXCOUNT || r_phase == PH_LOCKTIME))
    `BSFP_ASSERT(a_script_nonempty, i_clk, i_rst_n, r_phase == PH_INSCRIPT || r_phase == PH_OUTSCRIPT, r_script_left != '0)

endmodule

>>> rtl/core/bsfp_out_reg.sv
// Result register between the parser logic and the output channel.
`timescale 1ns / 1ps
module bsfp_out_reg
    import bsfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_fire,
    output logic    o_out_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // A held result that the consumer keeps stalling blocks the next transfer in.
    assign o_in_stall  = r_valid && i_out_stall;
    assign o_fire      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fire) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fire) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/core/block_stream_field_parser_core.sv
// Top level of the serialized block stream field parser.
`timescale 1ns / 1ps
// Takes one byte of a serialized block per transfer and returns one tagged
// result per byte, in order: field kind, offset within the field, end-of-field
// and end-of-block flags, transaction and entry numbers, and the decoded
// variable-length integer on its final byte. One byte is taken every cycle
// unless a held result is stalled by the receiver; each result is registered
// and appears on the output in the cycle after its input transfer. Each byte
// makes a single parser state update, held in one set of registers. Counts
// and script lengths that do not fit in COUNT_WIDTH bits are reported and
// then every later byte is tagged as error until reset.
module block_stream_field_parser_core
    import bsfp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_byte_out,
    output logic [4:0]  o_field_kind,
    output logic [4:0]  o_byte_offset,
    output logic        o_field_last,
    output logic        o_value_valid,
    output logic [63:0] o_varint_value,
    output logic [31:0] o_tx_number,
    output logic [31:0] o_item_number,
    output logic        o_block_last
);

    logic    fire;
    t_result step_res;
    t_result out_res;

    bsfp_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_data_byte),
        .o_res       (step_res)
    );

    bsfp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_res       (step_res),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_fire      (fire),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_byte_out     = out_res.byte_out;
    assign o_field_kind   = out_res.field_kind;
    assign o_byte_offset  = out_res.byte_offset;
    assign o_field_last   = out_res.field_last;
    assign o_value_valid  = out_res.value_valid;
    assign o_varint_value = out_res.varint_value;
    assign o_tx_number    = out_res.tx_number;
    assign o_item_number  = out_res.item_number;
    assign o_block_last   = out_res.block_last;

endmodule

>>> test/bsfp_tag_checker.sv
// Predicts the tag of every accepted byte and compares it with the parser output.
`timescale 1ns / 1ps
module bsfp_tag_checker
    import bsfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    // Parser state with counters at the widths of the block, with COUNT_WIDTH = 32; the phase is a field kind code.
    logic [4:0]  phase;
    logic [5:0]  field_count;
    logic [3:0]  varint_len;
    logic [63:0] varint_acc;
    logic [31:0] tx_left;
    logic [31:0] tx_index;
    logic [31:0] inputs_left;
    logic [31:0] outputs_left;
    logic [31:0] entry_index;
    logic [31:0] script_left;

    t_result pending_tags[$];
    int      fail_total = 0;

    function automatic logic [5:0] field_length(input logic [4:0] ph);
        case (ph)
            K_PREVHASH, K_MERKLE, K_INHASH: return 6'd32;
            K_OUTVALUE:                     return 6'd8;
            default:                        return 6'd4;
        endcase
    endfunction

    function automatic void enter_phase(input logic [4:0] ph);
        phase = ph;
        field_count = '0;
        varint_len = '0;
        varint_acc = '0;
    endfunction

    function automatic void clear_parser();
        enter_phase(K_MAGIC);
        tx_left = '0;
        tx_index = '0;
        inputs_left = '0;
        outputs_left = '0;
        entry_index = '0;
        script_left = '0;
    endfunction

    // Returns 1 when the finished transaction was the last one of the block.
    function automatic logic finish_tx();
        tx_left = tx_left - 1;
        tx_index = tx_index + 1;
        if (tx_left == 0) begin
            enter_phase(K_MAGIC);
            return 1'b1;
        end
        enter_phase(K_TXVER);
        return 1'b0;
    endfunction

    function automatic void finish_output();
        outputs_left = outputs_left - 1;
        entry_index = entry_index + 1;
        enter_phase(outputs_left == 0 ? K_LOCKTIME : K_OUTVALUE);
    endfunction

    task automatic tag_byte(input logic [7:0] data, output t_result tag);
        logic [4:0]  ph;
        logic        done;
        logic [63:0] value;
        ph = phase;
        done = 1'b0;
        tag = '0;
        tag.byte_out = data;
        if (ph == K_ERROR) begin
            tag.field_kind = K_ERROR;
            return;
        end
        tag.field_kind = ph;
        tag.byte_offset = field_count[4:0];
        if (ph >= K_TXVER) tag.tx_number = tx_index;
        if ((ph >= K_INHASH && ph <= K_INSEQ) || (ph >= K_OUTVALUE && ph <= K_OUTSCRIPT))
            tag.item_number = entry_index;

        if (ph == K_TXCOUNT || ph == K_INCOUNT || ph == K_INSCRIPTLEN ||
            ph == K_OUTCOUNT || ph == K_OUTSCRIPTLEN) begin
            if (field_count == 0) begin
                if (data < VI_PFX_2) begin
                    varint_acc = {56'd0, data};
                    done = 1'b1;
                end else begin
                    varint_len = (data == VI_PFX_2) ? VI_LEN_2 :
                                 (data == VI_PFX_4) ? VI_LEN_4 : VI_LEN_8;
                    varint_acc = '0;
                    field_count = 6'd1;
                end
            end else begin
                varint_acc = varint_acc | ({56'd0, data} << (8 * (field_count - 1)));
                if (field_count >= varint_len) done = 1'b1;
                else field_count = field_count + 1;
            end
            if (done) begin
                value = varint_acc;
                tag.field_last = 1'b1;
                tag.value_valid = 1'b1;
                tag.varint_value = value;
                if (value[63:32] != 0) begin
                    enter_phase(K_ERROR);
                end else begin
                    case (ph)
                        K_TXCOUNT: begin
                            tx_left = value[31:0];
                            tx_index = '0;
                            if (value == 0) begin
                                enter_phase(K_MAGIC);
                                tag.block_last = 1'b1;
                            end else begin
                                enter_phase(K_TXVER);
                            end
                        end
                        K_INCOUNT: begin
                            inputs_left = value[31:0];
                            entry_index = '0;
                            enter_phase(value == 0 ? K_OUTCOUNT : K_INHASH);
                        end
                        K_OUTCOUNT: begin
                            outputs_left = value[31:0];
                            entry_index = '0;
                            enter_phase(value == 0 ? K_LOCKTIME : K_OUTVALUE);
                        end
                        K_INSCRIPTLEN: begin
                            script_left = value[31:0];
                            enter_phase(value == 0 ? K_INSEQ : K_INSCRIPT);
                        end
                        default: begin
                            script_left = value[31:0];
                            if (value == 0) finish_output();
                            else enter_phase(K_OUTSCRIPT);
                        end
                    endcase
                end
            end
        end else if (ph == K_INSCRIPT || ph == K_OUTSCRIPT) begin
            field_count = field_count + 1;
            script_left = script_left - 1;
            if (script_left == 0) begin
                tag.field_last = 1'b1;
                if (ph == K_INSCRIPT) enter_phase(K_INSEQ);
                else finish_output();
            end
        end else begin
            field_count = field_count + 1;
            if (field_count >= field_length(ph)) begin
                tag.field_last = 1'b1;
                if (ph == K_INSEQ) begin
                    inputs_left = inputs_left - 1;
                    entry_index = entry_index + 1;
                    enter_phase(inputs_left == 0 ? K_OUTCOUNT : K_INHASH);
                end else if (ph == K_LOCKTIME) begin
                    tag.block_last = finish_tx();
                end else begin
                    // Every other fixed field is followed by the next phase in order.
                    enter_phase(ph + 5'd1);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_parser();
            pending_tags.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_tags.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, i_result);
                end else begin
                    want = pending_tags.pop_front();
                    check_field("byte_out", want.byte_out, i_result.byte_out);
                    check_field("field_kind", want.field_kind, i_result.field_kind);
                    check_field("byte_offset", want.byte_offset, i_result.byte_offset);
                    check_field("field_last", want.field_last, i_result.field_last);
                    check_field("value_valid", want.value_valid, i_result.value_valid);
                    check_field("varint_value", want.varint_value, i_result.varint_value);
                    check_field("tx_number", want.tx_number, i_result.tx_number);
                    check_field("item_number", want.item_number, i_result.item_number);
                    check_field("block_last", want.block_last, i_result.block_last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                tag_byte(i_data_byte, want);
                pending_tags.push_back(want);
            end
        end
        o_pending <= pending_tags.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> test/tb_top.sv
// Stimulus and verdict for the block stream field parser.
`timescale 1ns / 1ps
module tb_top;
    import bsfp_pkg::*;

    localparam logic [7:0] VI_PFX_8 = 8'hff;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  byte_out;
    logic [4:0]  field_kind;
    logic [4:0]  byte_offset;
    logic        field_last;
    logic        value_valid;
    logic [63:0] varint_value;
    logic [31:0] tx_number;
    logic [31:0] item_number;
    logic        block_last;
    int          fail_count;
    int          pending;

    int          bytes_sent = 0;
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;
    int          stall_left = 0;

    always #5 clk = ~clk;

    block_stream_field_parser_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_byte_out     (byte_out),
        .o_field_kind   (field_kind),
        .o_byte_offset  (byte_offset),
        .o_field_last   (field_last),
        .o_value_valid  (value_valid),
        .o_varint_value (varint_value),
        .o_tx_number    (tx_number),
        .o_item_number  (item_number),
        .o_block_last   (block_last)
    );

    bsfp_tag_checker tag_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_data_byte  (data_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_result     ({byte_out, field_kind, byte_offset, field_last, value_valid,
                        varint_value, tx_number, item_number, block_last}),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The receiver stalls for a random number of cycles after each transfer,
    // with occasional quiet stretches where it never stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            stall_left = 0;
        end else if (out_valid && !out_stall) begin
            if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
            stall_left = rx_quiet ? 0 : $urandom_range(0, 8);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    task automatic send_byte(input logic [7:0] data);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_byte($urandom_range(0, 255));
    endtask

    // Sends a variable-length integer with the given number of extra bytes
    // (zero means the single-byte form).
    task automatic send_varint(input logic [63:0] value, input int extra);
        if (extra == 0) begin
            send_byte(value[7:0]);
        end else begin
            send_byte(extra == VI_LEN_2 ? VI_PFX_2 : extra == VI_LEN_4 ? VI_PFX_4 : VI_PFX_8);
            for (int i = 0; i < extra; i++) send_byte(value[8 * i +: 8]);
        end
    endtask

    // Picks any encoding wide enough for the value, including padded ones.
    task automatic send_count(input logic [63:0] value);
        int form;
        form = $urandom_range(0, 5);
        if (form <= 2 && value < VI_PFX_2) send_varint(value, 0);
        else if (form <= 3 && value < 64'h1_0000) send_varint(value, VI_LEN_2);
        else if (form <= 4 && value < 64'h1_0000_0000) send_varint(value, VI_LEN_4);
        else send_varint(value, VI_LEN_8);
    endtask

    task automatic send_block(input int n_tx, input int lo_entries, input int hi_entries,
                              input int max_script);
        int n_in;
        int n_out;
        int script_len;
        send_random(88);
        send_count(n_tx);
        repeat (n_tx) begin
            send_random(4);
            n_in = $urandom_range(lo_entries, hi_entries);
            send_count(n_in);
            repeat (n_in) begin
                send_random(36);
                script_len = $urandom_range(0, max_script);
                send_count(script_len);
                send_random(script_len);
                send_random(4);
            end
            n_out = $urandom_range(lo_entries, hi_entries);
            send_count(n_out);
            repeat (n_out) begin
                send_random(8);
                script_len = $urandom_range(0, max_script);
                send_count(script_len);
                send_random(script_len);
            end
            send_random(4);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks: an empty block, transactions without inputs or
        // outputs, and single entries with empty scripts.
        send_block(0, 0, 0, 0);
        send_block(1, 0, 0, 0);
        send_block(1, 1, 1, 0);
        in_valid <= 1'b0;
        wait_drained();

        // Random blocks; scripts of up to 40 bytes, or at times 100, run past the 32-byte offset wrap.
        while (bytes_sent < 600) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            send_block($urandom_range(0, 3), 0, 3,
                       ($urandom_range(0, 15) == 0) ? 100 : 40);
        end

        // The error phase is sticky, so it closes the run: a transaction count
        // at the top of the counter range is still legal, then an input count
        // beyond it moves the parser into error for all later bytes.
        in_valid <= 1'b0;
        wait_drained();
        tx_quiet = 1'b0;
        send_random(88);
        send_varint(64'hffff_ffff, VI_LEN_8);
        send_random(4);
        send_varint({1'b1, 31'($urandom), 32'($urandom)}, VI_LEN_8);
        send_random(20);
        in_valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bsfp_pkg.sv
rtl/core/bsfp_step.sv
rtl/core/bsfp_out_reg.sv
rtl/core/block_stream_field_parser_core.sv
test/bsfp_tag_checker.sv
test/tb_top.sv
